@@ sv/char_lcd_message_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD message sequencer
// Clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_MESSAGE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_MESSAGE_SEQUENCER_ASSERT_SVH

// Check a property at every clock edge outside reset
`define CLMSEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define CLMSEQ_ASSERT_NEVER(label, expr, msg) \
  `CLMSEQ_ASSERT(label, !(expr), msg)

`endif

@@ sv/clmseq_pkg.sv @@
// ----------------------------------------------------------------------------
// clmseq_pkg
// Types, codes and tables shared by the LCD message sequencer modules.
// ----------------------------------------------------------------------------
package clmseq_pkg;

  // Action codes
  localparam logic [1:0] ACT_BACKLIGHT = 2'd0;
  localparam logic [1:0] ACT_WRITE     = 2'd1;
  localparam logic [1:0] ACT_PAUSE     = 2'd2;

  // Wait classes
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_SHORT = 2'd1;
  localparam logic [1:0] WAIT_TICK  = 2'd2;
  localparam logic [1:0] WAIT_LONG  = 2'd3;

  // Register select
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  localparam logic [7:0] CMD_LINE_TWO = 8'hc0;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Sequencer steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_POWER      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CHAR       = 4'd10;
  localparam logic [STEP_W-1:0] STEP_PAUSE      = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LIGHT      = 4'd12;
  localparam logic [STEP_W-1:0] STEP_DONE       = 4'd13;

  // Init command table
  localparam int unsigned INIT_LEN = 9;
  localparam logic [7:0] INIT_BYTES [INIT_LEN] = '{
    8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h0c, 8'h02
  };
  localparam logic [1:0] INIT_WAITS [INIT_LEN] = '{
    WAIT_TICK, WAIT_SHORT, WAIT_SHORT, WAIT_SHORT, WAIT_SHORT,
    WAIT_TICK, WAIT_TICK, WAIT_SHORT, WAIT_TICK
  };

  // Back end sequencer state
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // Classified item from the front end
  typedef struct packed {
    logic       need_init;
    logic       has_char;
    logic       newline;
    logic [7:0] char_code;
    logic       last;
    logic       important;
  } desc_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } queue_head_t;

  // First step of an item
  function automatic logic [STEP_W-1:0] first_step(input desc_t d);
    logic [STEP_W-1:0] s;
    if (d.need_init) begin
      s = STEP_POWER;
    end else if (d.has_char) begin
      s = STEP_CHAR;
    end else if (d.last) begin
      s = STEP_PAUSE;
    end else begin
      s = STEP_DONE;
    end
    return s;
  endfunction

  // Step that follows s for item d, STEP_DONE when s closes the item
  function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s,
                                                  input desc_t d);
    logic [STEP_W-1:0] n;
    n = STEP_DONE;
    case (s) inside
      [STEP_POWER:4'd8]: n = s + 4'd1;
      STEP_INIT_LAST: begin
        if (d.has_char) begin
          n = STEP_CHAR;
        end else if (d.last) begin
          n = STEP_PAUSE;
        end
      end
      STEP_CHAR: begin
        if (d.last) begin
          n = STEP_PAUSE;
        end
      end
      STEP_PAUSE: n = STEP_LIGHT;
      default:    n = STEP_DONE;
    endcase
    return n;
  endfunction

endpackage

@@ sv/clmseq_if.sv @@
// ----------------------------------------------------------------------------
// clmseq_in_if / clmseq_out_if
// Valid/ready channels for message items and LCD action items.
// ----------------------------------------------------------------------------
interface clmseq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_character;
  logic       last_of_message;
  logic       important;

  modport source (output valid, character, has_character, last_of_message,
                  important, input ready);
  modport sink   (input valid, character, has_character, last_of_message,
                  important, output ready);
endinterface

interface clmseq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       register_select;
  logic [7:0] bus_byte;
  logic       backlight_on;
  logic [1:0] wait_class;
  logic       last_result;

  modport source (output valid, action, register_select, bus_byte, backlight_on,
                  wait_class, last_result, input ready);
  modport sink   (input valid, action, register_select, bus_byte, backlight_on,
                  wait_class, last_result, output ready);
endinterface

@@ sv/clmseq_front.sv @@
// ----------------------------------------------------------------------------
// clmseq_front
// Accepts message items, tracks the open message and classifies each item.
// ----------------------------------------------------------------------------
module clmseq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clmseq_in_if.sink             in_if,
  output logic                  push_valid_o,
  output clmseq_pkg::desc_t     push_desc_o,
  input  logic                  push_ready_i
);
  import clmseq_pkg::*;

  logic  open_q, open_d;
  logic  accept;
  desc_t desc;

  // Stall the input while the queue is full
  assign in_if.ready = push_ready_i;
  assign accept      = in_if.valid && push_ready_i;

  // Classify the item
  always_comb begin
    desc.need_init = !open_q;
    desc.has_char  = in_if.has_character;
    desc.newline   = (in_if.character == NEWLINE_CODE);
    desc.char_code = in_if.character;
    desc.last      = in_if.last_of_message;
    desc.important = in_if.important;
  end

  // Drop items that cause no action
  assign push_valid_o = accept && (desc.need_init || desc.has_char || desc.last);
  assign push_desc_o  = desc;

  // Open on any accepted item, close on the last one
  assign open_d = accept ? !in_if.last_of_message : open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

@@ sv/clmseq_queue.sv @@
// ----------------------------------------------------------------------------
// clmseq_queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module clmseq_queue #(
  parameter int unsigned Depth = clmseq_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  input  clmseq_pkg::desc_t       push_desc_i,
  output logic                    push_ready_o,
  output clmseq_pkg::queue_head_t head_o,
  input  logic                    pop_i
);
  import clmseq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  desc_t           entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.desc  = entries_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

@@ sv/clmseq_back.sv @@
// ----------------------------------------------------------------------------
// clmseq_back
// Steps through the LCD actions of each queued item, one action per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`include "char_lcd_message_sequencer_assert.svh"

module clmseq_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  clmseq_pkg::queue_head_t head_i,
  output logic                    pop_o,
  clmseq_out_if.source            out_if
);
  import clmseq_pkg::*;

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] step_sel, step_nxt;
  logic [STEP_W-1:0] init_idx;
  logic              load, is_final;

  logic       out_valid_q;
  logic [1:0] action_q, action_d;
  logic       rs_q, rs_d;
  logic [7:0] byte_q, byte_d;
  logic       light_q, light_d;
  logic [1:0] wait_q, wait_d;
  logic       last_q;

  // Pick the current step and its successor
  assign step_sel = (state_q == SEQ_RUN) ? step_q : first_step(head_i.desc);
  assign step_nxt = next_step(step_sel, head_i.desc);
  assign is_final = (step_nxt == STEP_DONE);
  assign init_idx = step_sel - STEP_INIT_FIRST;
  assign load     = head_i.valid && (!out_valid_q || out_if.ready);
  assign pop_o    = load && is_final;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      SEQ_IDLE: begin
        if (load && !is_final) begin
          state_d = SEQ_RUN;
          step_d  = step_nxt;
        end
      end
      SEQ_RUN: begin
        if (load) begin
          step_d = step_nxt;
          if (is_final) begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Build the action for the current step
  always_comb begin
    action_d = ACT_WRITE;
    rs_d     = RS_COMMAND;
    byte_d   = '0;
    light_d  = 1'b0;
    wait_d   = WAIT_SHORT;
    case (step_sel) inside
      STEP_POWER: begin
        action_d = ACT_BACKLIGHT;
        light_d  = 1'b1;
        wait_d   = WAIT_LONG;
      end
      [STEP_INIT_FIRST:STEP_INIT_LAST]: begin
        byte_d = INIT_BYTES[init_idx];
        wait_d = INIT_WAITS[init_idx];
      end
      STEP_CHAR: begin
        if (head_i.desc.newline) begin
          byte_d = CMD_LINE_TWO;
        end else begin
          rs_d   = RS_DATA;
          byte_d = head_i.desc.char_code;
        end
      end
      STEP_PAUSE: begin
        action_d = ACT_PAUSE;
      end
      default: begin
        action_d = ACT_BACKLIGHT;
        light_d  = head_i.desc.important;
        wait_d   = WAIT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      step_q      <= STEP_POWER;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q <= action_d;
      rs_q     <= rs_d;
      byte_q   <= byte_d;
      light_q  <= light_d;
      wait_q   <= wait_d;
      last_q   <= is_final;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.action          = action_q;
  assign out_if.register_select = rs_q;
  assign out_if.bus_byte        = byte_q;
  assign out_if.backlight_on    = light_q;
  assign out_if.wait_class      = wait_q;
  assign out_if.last_result     = last_q;

  `CLMSEQ_ASSERT(a_run_has_head, (state_q == SEQ_RUN) |-> head_i.valid, "running with empty queue")
  `CLMSEQ_ASSERT(a_run_step_range, (state_q == SEQ_RUN) |-> (step_q >= STEP_INIT_FIRST && step_q <= STEP_LIGHT), "step out of range")
  `CLMSEQ_ASSERT(a_write_waits, (out_valid_q && action_q == ACT_WRITE) |-> (wait_q != WAIT_NONE), "bus write without wait")
  `CLMSEQ_ASSERT_NEVER(a_idle_fields, out_valid_q && action_q != ACT_WRITE && (rs_q || byte_q != 8'h00), "bus fields set on non-write")

endmodule

@@ sv/char_lcd_message_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_message_sequencer: message items in, LCD actions out, one per cycle unless stalled.
// Path: an item enters the queue at its accept edge; with the back end idle
// its first action then passes through the output register to the output.
// Actions: one per cycle unless stalled; a first item gives up to 13, a character 1.
// Reset: asynchronous, active low; clears the open message, queue and output.
// ----------------------------------------------------------------------------
module char_lcd_message_sequencer #(
  parameter int unsigned QueueDepth = clmseq_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clmseq_in_if.sink    in_if,
  clmseq_out_if.source out_if
);
  import clmseq_pkg::*;

  logic        push_valid;
  logic        push_ready;
  desc_t       push_desc;
  queue_head_t head;
  logic        pop;

  // Accept and classify items
  clmseq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_desc_o  (push_desc),
    .push_ready_i (push_ready)
  );

  // Decouple front and back
  clmseq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Emit LCD actions
  clmseq_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_if (out_if)
  );

endmodule
